FILE: rtl/core/c2s_pkg.sv
package c2s_pkg;

    // Stream payload widths
    localparam int C2S_COORD_W  = 16;
    localparam int C2S_DIFF_W   = C2S_COORD_W + 1;
    localparam int C2S_SQ_W     = 2 * C2S_COORD_W;
    localparam int C2S_HSQ_W    = C2S_SQ_W + 1;
    localparam int C2S_FSQ_W    = C2S_SQ_W + 2;
    localparam int C2S_S_DATA_W = 6 * C2S_COORD_W;
    localparam int C2S_ANGLE_W  = 16;
    localparam int C2S_DIST_W   = 24;
    localparam int C2S_M_DATA_W = 2 * C2S_ANGLE_W + C2S_DIST_W;
    localparam int C2S_ATTEN_W  = 16;
    localparam logic [C2S_ATTEN_W-1:0] C2S_ATTEN_RESET = 16'd256;

    // Square root unit: radicand and root widths
    localparam int C2S_RAD_W   = 62;
    localparam int C2S_ROOT_W  = C2S_RAD_W / 2;
    localparam int C2S_HSHIFT  = 28;
    localparam int C2S_FSHIFT  = 16;
    localparam int C2S_LEN_W   = 25;
    localparam int C2S_PROD_W  = C2S_LEN_W + C2S_ATTEN_W;

    // CORDIC
    localparam int C2S_CORDIC_STEPS = 16;
    localparam int C2S_CORD_IN_W    = 32;
    localparam int C2S_PRESCALE     = 20;
    localparam int C2S_EL_SHIFT     = 14;
    localparam int C2S_ACC_W        = 34;
    localparam int C2S_ATAN_W       = 32;
    localparam int C2S_ATAN_IDX_W   = 5;
    localparam int C2S_ROUND_SH     = 16;
    localparam logic signed [C2S_ACC_W-1:0] C2S_QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [C2S_ACC_W:0]   C2S_ANGLE_HALF   = 35'sd32768;
    localparam logic signed [C2S_ACC_W-C2S_ROUND_SH:0] C2S_EL_MAX = 19'sd16384;
    localparam logic signed [C2S_ACC_W-C2S_ROUND_SH:0] C2S_EL_MIN = -19'sd16384;
    localparam logic [C2S_PROD_W:0] C2S_DIST_HALF = 42'd32768;
    localparam logic [C2S_DIST_W-1:0] C2S_DIST_MAX = 24'hFFFFFF;

    // arctan(2^-i), 2^31 = pi
    function automatic logic [C2S_ATAN_W-1:0] c2s_atan(input logic [C2S_ATAN_IDX_W-1:0] i);
        logic [C2S_ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/c2s_isqrt.sv
// Two-lane pipelined integer square root, one root bit per stage.
module c2s_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [c2s_pkg::C2S_RAD_W-1:0]    rad_a,
    input  logic [c2s_pkg::C2S_RAD_W-1:0]    rad_b,
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             out_valid,
    output logic [c2s_pkg::C2S_ROOT_W-1:0]   root_a,
    output logic [c2s_pkg::C2S_ROOT_W-1:0]   root_b,
    output logic [SIDE_W-1:0]                side_out
);
    import c2s_pkg::*;

    localparam int NR = C2S_ROOT_W;
    localparam int RW = NR + 3;

    logic [1:0][C2S_RAD_W-1:0] rad_reg  [NR];
    logic [1:0][RW-1:0]        rem_reg  [NR];
    logic [1:0][NR-1:0]        root_reg [NR];
    logic [SIDE_W-1:0]         side_reg [NR];
    logic [NR-1:0]             valid_reg;

    for (genvar k = 0; k < NR; k++) begin : g_stage
        logic [1:0][C2S_RAD_W-1:0] rad_prev, rad_next;
        logic [1:0][RW-1:0]        rem_prev, rem_next, rem_cat, trial;
        logic [1:0][NR-1:0]        root_prev, root_next;
        logic [SIDE_W-1:0]         side_prev;
        logic                      valid_prev;

        if (k == 0) begin : g_head
            assign rad_prev   = {rad_b, rad_a};
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end else begin : g_body
            assign rad_prev   = rad_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        always_comb begin
            for (int j = 0; j < 2; j++) begin
                rem_cat[j] = {rem_prev[j][RW-3:0], rad_prev[j][C2S_RAD_W-1 -: 2]};
                trial[j]   = {1'b0, root_prev[j], 2'b01};
                if (rem_cat[j] >= trial[j]) begin
                    rem_next[j]  = rem_cat[j] - trial[j];
                    root_next[j] = {root_prev[j][NR-2:0], 1'b1};
                end else begin
                    rem_next[j]  = rem_cat[j];
                    root_next[j] = {root_prev[j][NR-2:0], 1'b0};
                end
                rad_next[j] = rad_prev[j] << 2;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[NR-1];
    assign root_a    = root_reg[NR-1][0];
    assign root_b    = root_reg[NR-1][1];
    assign side_out  = side_reg[NR-1];

endmodule

FILE: rtl/core/c2s_cordic.sv
// Two-lane unrolled CORDIC vectoring: quadrant fold, then one iteration per stage.
module c2s_cordic #(
    parameter int STEPS  = c2s_pkg::C2S_CORDIC_STEPS,
    parameter int SIDE_W = 1
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [c2s_pkg::C2S_CORD_IN_W-1:0] x_in [2],
    input  logic signed [c2s_pkg::C2S_CORD_IN_W-1:0] y_in [2],
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   out_valid,
    output logic signed [c2s_pkg::C2S_ACC_W-1:0]   acc_out [2],
    output logic [SIDE_W-1:0]                      side_out
);
    import c2s_pkg::*;

    localparam int IW  = C2S_CORD_IN_W;
    localparam int W   = IW + C2S_PRESCALE + 3;
    localparam int EXT = W - IW - C2S_PRESCALE;

    logic signed [W-1:0]         x_reg    [STEPS+1][2];
    logic signed [W-1:0]         y_reg    [STEPS+1][2];
    logic signed [C2S_ACC_W-1:0] acc_reg  [STEPS+1][2];
    logic [1:0]                  zero_reg [STEPS+1];
    logic [SIDE_W-1:0]           side_reg [STEPS+1];
    logic [STEPS:0]              valid_reg;

    // quadrant fold into the right half plane
    logic signed [W-1:0]         xp [2];
    logic signed [W-1:0]         yp [2];
    logic signed [W-1:0]         x0_next [2];
    logic signed [W-1:0]         y0_next [2];
    logic signed [C2S_ACC_W-1:0] acc0_next [2];
    logic [1:0]                  zero_next;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            xp[j] = {{EXT{x_in[j][IW-1]}}, x_in[j], {C2S_PRESCALE{1'b0}}};
            yp[j] = {{EXT{y_in[j][IW-1]}}, y_in[j], {C2S_PRESCALE{1'b0}}};
            zero_next[j] = (x_in[j] == '0) && (y_in[j] == '0);
            if (xp[j] < 0) begin
                if (yp[j] >= 0) begin
                    x0_next[j]   = yp[j];
                    y0_next[j]   = -xp[j];
                    acc0_next[j] = C2S_QUARTER_TURN;
                end else begin
                    x0_next[j]   = -yp[j];
                    y0_next[j]   = xp[j];
                    acc0_next[j] = -C2S_QUARTER_TURN;
                end
            end else begin
                x0_next[j]   = xp[j];
                y0_next[j]   = yp[j];
                acc0_next[j] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                x_reg[0][j]   <= x0_next[j];
                y_reg[0][j]   <= y0_next[j];
                acc_reg[0][j] <= acc0_next[j];
            end
            zero_reg[0] <= zero_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_iter
        logic signed [C2S_ACC_W-1:0] ang;
        logic signed [W-1:0]         xs [2];
        logic signed [W-1:0]         ys [2];
        logic signed [W-1:0]         x_next [2];
        logic signed [W-1:0]         y_next [2];
        logic signed [C2S_ACC_W-1:0] acc_next [2];

        assign ang = $signed({{(C2S_ACC_W-C2S_ATAN_W){1'b0}},
                              c2s_atan(C2S_ATAN_IDX_W'(k-1))});

        always_comb begin
            for (int j = 0; j < 2; j++) begin
                xs[j] = x_reg[k-1][j] >>> (k-1);
                ys[j] = y_reg[k-1][j] >>> (k-1);
                if (y_reg[k-1][j] > 0) begin
                    x_next[j]   = x_reg[k-1][j] + ys[j];
                    y_next[j]   = y_reg[k-1][j] - xs[j];
                    acc_next[j] = acc_reg[k-1][j] + ang;
                end else begin
                    x_next[j]   = x_reg[k-1][j] - ys[j];
                    y_next[j]   = y_reg[k-1][j] + xs[j];
                    acc_next[j] = acc_reg[k-1][j] - ang;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 2; j++) begin
                    x_reg[k][j]   <= x_next[j];
                    y_reg[k][j]   <= y_next[j];
                    acc_reg[k][j] <= acc_next[j];
                end
                zero_reg[k] <= zero_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // zero vector reads as angle 0
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            acc_out[j] = zero_reg[STEPS][j] ? '0 : acc_reg[STEPS][j];
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

FILE: rtl/core/cartesian_to_spherical_panner_core.sv
// Channel   | Dir | Ports                      | Contents
// s_ (in)   | in  | s_tvalid s_tready s_tdata  | source x,y,z, target x,y,z (Q8.8)
// m_ (out)  | out | m_tvalid m_tready m_tdata  | azimuth, elevation, scaled distance
// cfg       | in  | cfg_wr_en cfg_wr_data      | attenuation (Q8.8, reset 256)
//
// One item per cycle sustained while m_ is not stalled. The pipe runs through the
// difference/square/sum stages, 31 root stages of the square root unit, the
// CORDIC fold and iteration stages, then the scale multiply and output register.
// Reset (aresetn low, synchronous) clears all valid bits and loads attenuation.
// A stall on m_ freezes the whole pipe in place; s_tready drops only while the
// output register holds an item that is not taken.
module cartesian_to_spherical_panner_core #(
    parameter int CORDIC_STEPS = c2s_pkg::C2S_CORDIC_STEPS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // source_x, source_y, source_z, target_x, target_y, target_z
    input  logic [c2s_pkg::C2S_S_DATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // azimuth, elevation, scaled_distance
    output logic [c2s_pkg::C2S_M_DATA_W-1:0]   m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [c2s_pkg::C2S_ATTEN_W-1:0]    cfg_wr_data
);
    import c2s_pkg::*;

    localparam int CW = C2S_COORD_W;
    localparam int DW = C2S_DIFF_W;

    logic                   en;
    logic [C2S_ATTEN_W-1:0] atten_reg;

    // pipe advances unless the output register is full and blocked
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atten_reg <= C2S_ATTEN_RESET;
        end else if (cfg_wr_en) begin
            atten_reg <= cfg_wr_data;
        end
    end

    // ---- stage A: differences (exact, 17-bit)
    logic signed [CW-1:0] sx, sy, sz, tx, ty, tz;
    logic                 va_reg;
    logic signed [DW-1:0] dxa_reg, dya_reg, dza_reg;

    assign sx = s_tdata[0*CW +: CW];
    assign sy = s_tdata[1*CW +: CW];
    assign sz = s_tdata[2*CW +: CW];
    assign tx = s_tdata[3*CW +: CW];
    assign ty = s_tdata[4*CW +: CW];
    assign tz = s_tdata[5*CW +: CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxa_reg <= DW'(tx) - DW'(sx);
            dya_reg <= DW'(ty) - DW'(sy);
            dza_reg <= DW'(tz) - DW'(sz);
        end
    end

    // ---- stage B: squares
    logic                 vb_reg;
    logic signed [DW-1:0] dxb_reg, dyb_reg, dzb_reg;
    logic [C2S_SQ_W-1:0]  xsq_reg, ysq_reg, zsq_reg;
    logic signed [2*DW-1:0] xsq_full, ysq_full, zsq_full;

    assign xsq_full = dxa_reg * dxa_reg;
    assign ysq_full = dya_reg * dya_reg;
    assign zsq_full = dza_reg * dza_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxb_reg <= dxa_reg;
            dyb_reg <= dya_reg;
            dzb_reg <= dza_reg;
            xsq_reg <= xsq_full[C2S_SQ_W-1:0];
            ysq_reg <= ysq_full[C2S_SQ_W-1:0];
            zsq_reg <= zsq_full[C2S_SQ_W-1:0];
        end
    end

    // ---- stage C: horizontal and full squared lengths
    logic                 vc_reg;
    logic signed [DW-1:0] dxc_reg, dyc_reg, dzc_reg;
    logic [C2S_HSQ_W-1:0] hsq_reg, hsq_next;
    logic [C2S_FSQ_W-1:0] fsq_reg;

    assign hsq_next = C2S_HSQ_W'(xsq_reg) + C2S_HSQ_W'(zsq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxc_reg <= dxb_reg;
            dyc_reg <= dyb_reg;
            dzc_reg <= dzb_reg;
            hsq_reg <= hsq_next;
            fsq_reg <= C2S_FSQ_W'(hsq_next) + C2S_FSQ_W'(ysq_reg);
        end
    end

    // ---- square roots: horizontal magnitude and full length
    logic [C2S_RAD_W-1:0]  rad_h, rad_f;
    logic [3*DW-1:0]       sq_side_out;
    logic                  vs;
    logic [C2S_ROOT_W-1:0] hmag, flen;

    assign rad_h = C2S_RAD_W'(hsq_reg) << C2S_HSHIFT;
    assign rad_f = C2S_RAD_W'(fsq_reg) << C2S_FSHIFT;

    c2s_isqrt #(
        .SIDE_W (3 * DW)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vc_reg),
        .rad_a     (rad_h),
        .rad_b     (rad_f),
        .side_in   ({dzc_reg, dyc_reg, dxc_reg}),
        .out_valid (vs),
        .root_a    (hmag),
        .root_b    (flen),
        .side_out  (sq_side_out)
    );

    // ---- CORDIC: lane 0 azimuth atan2(-dx,-dz), lane 1 elevation atan2(dy,h)
    logic signed [DW-1:0]            dxs, dys, dzs;
    logic signed [C2S_CORD_IN_W-1:0] cx [2];
    logic signed [C2S_CORD_IN_W-1:0] cy [2];
    logic signed [C2S_ACC_W-1:0]     acc [2];
    logic [C2S_LEN_W-1:0]            len_k;
    logic                            vk;

    assign dxs = sq_side_out[0*DW +: DW];
    assign dys = sq_side_out[1*DW +: DW];
    assign dzs = sq_side_out[2*DW +: DW];

    assign cx[0] = -C2S_CORD_IN_W'(dzs);
    assign cy[0] = -C2S_CORD_IN_W'(dxs);
    assign cx[1] = {1'b0, hmag};
    assign cy[1] = C2S_CORD_IN_W'(dys) <<< C2S_EL_SHIFT;

    c2s_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (C2S_LEN_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vs),
        .x_in      (cx),
        .y_in      (cy),
        .side_in   (flen[C2S_LEN_W-1:0]),
        .out_valid (vk),
        .acc_out   (acc),
        .side_out  (len_k)
    );

    // ---- stage P: scale multiply, angle rounding
    localparam int RAW = C2S_ACC_W - C2S_ROUND_SH + 1;
    logic                   vp_reg;
    logic [C2S_PROD_W-1:0]  prod_reg;
    logic signed [C2S_ACC_W:0] az_sum, el_sum;
    logic signed [RAW-1:0]  az_reg, el_reg;

    assign az_sum = {acc[0][C2S_ACC_W-1], acc[0]} + C2S_ANGLE_HALF;
    assign el_sum = {acc[1][C2S_ACC_W-1], acc[1]} + C2S_ANGLE_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= vk;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= C2S_PROD_W'(len_k) * C2S_PROD_W'(atten_reg);
            az_reg   <= az_sum[C2S_ACC_W:C2S_ROUND_SH];
            el_reg   <= el_sum[C2S_ACC_W:C2S_ROUND_SH];
        end
    end

    // ---- stage O: clamp, saturate, output register
    logic [C2S_PROD_W:0]             dist_sum;
    logic [C2S_PROD_W-C2S_ROUND_SH:0] dist_full;
    logic [C2S_DIST_W-1:0]           dist_next;
    logic signed [C2S_ANGLE_W-1:0]   el_next;
    logic                            mv_reg;
    logic [C2S_M_DATA_W-1:0]         mdata_reg;

    assign dist_sum  = {1'b0, prod_reg} + C2S_DIST_HALF;
    assign dist_full = dist_sum[C2S_PROD_W:C2S_ROUND_SH];

    always_comb begin
        if (dist_full > (C2S_PROD_W - C2S_ROUND_SH + 1)'(C2S_DIST_MAX)) begin
            dist_next = C2S_DIST_MAX;
        end else begin
            dist_next = dist_full[C2S_DIST_W-1:0];
        end
        // residue past straight up or down clamps to +-pi/2
        if (el_reg > C2S_EL_MAX) begin
            el_next = C2S_EL_MAX[C2S_ANGLE_W-1:0];
        end else if (el_reg < C2S_EL_MIN) begin
            el_next = C2S_EL_MIN[C2S_ANGLE_W-1:0];
        end else begin
            el_next = el_reg[C2S_ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= vp_reg;
        end
    end

    // azimuth keeps the low 16 bits, so straight behind wraps to -pi
    always_ff @(posedge aclk) begin
        if (en) begin
            mdata_reg <= {dist_next, el_next, az_reg[C2S_ANGLE_W-1:0]};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

endmodule
